>>> rtl/bpa_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap page allocator package
// Field widths, action and status codes, register indexes, and the command and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package bpa_pkg;

   // Port field widths.
   localparam int ACTION_W    = 2;
   localparam int PAGE_W      = 12;
   localparam int COUNT_W     = 13;
   localparam int STATUS_W    = 2;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 13;

   // Request actions.
   localparam logic [ACTION_W-1:0] ACT_INIT  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_FREE  = 2'd2;

   // Response status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_MEM      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_DOUBLE_FREE = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_RANGE       = 2'd3;

   // Register indexes on the CSR port.
   localparam logic [CSR_INDEX_W-1:0] REG_PAGES    = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_RESERVED = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;      // latch the request beat
      logic fill_begin;   // start a bitmap sweep
      logic fill_zero;    // the sweep clears every page
      logic fill_run;     // write one map word and advance
      logic scan_begin;   // restart the allocation scan at word zero
      logic scan_run;     // issue one map read for the scan
      logic alloc_commit; // mark the found page used
      logic alloc_fail;   // report out of memory
      logic free_oor;     // report a page beyond the managed total
      logic free_read;    // read the word holding the page to free
      logic free_commit;  // clear the page or report a double free
      logic nop_result;   // unused action: report current counts only
      logic rsp_load;     // move the result into the output register
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic fill_last;    // the sweep is at the last map word
      logic chk_valid;    // scan read data is present this cycle
      logic found;        // the checked word holds a free page in range
      logic last_word;    // the checked word reaches the managed total
      logic free_oor;     // the page to free is beyond the managed total
   } dp_stat_type;

endpackage

>>> rtl/bitmap_page_allocator_core.sv
// From request beat to response beat, initialize sweeps every map word and allocate reads one
// bitmap word per cycle until it finds a free page or reaches the managed total. One request
// is in flight at a time; the bitmap memory's single read port sets the scan rate. After reset
// a clearing pass writes all MAP_WORDS words (128 at the defaults) while req_ready stays low;
// CSR writes are taken throughout. WORD_BITS must be a power of two; the block does not check.
// ----------------------------------------------------------------------------
// Bitmap page allocator core
// First-fit physical page allocator keeping one used bit per page in a word
// memory, with a used-page count reported on every response.
// ----------------------------------------------------------------------------
module bitmap_page_allocator_core #(
   parameter int MAX_PAGES          = 4096,
   parameter int WORD_BITS          = 32,
   parameter int LOW_RESERVED_PAGES = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_en,
   input  logic [bpa_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [bpa_pkg::CSR_DATA_W-1:0]    csr_write_data,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [bpa_pkg::ACTION_W-1:0]      req_action,
   input  logic [bpa_pkg::PAGE_W-1:0]        req_page_number,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [bpa_pkg::STATUS_W-1:0]      rsp_status,
   output logic [bpa_pkg::PAGE_W-1:0]        rsp_allocated_page,
   output logic [bpa_pkg::COUNT_W-1:0]       rsp_used_count,
   output logic [bpa_pkg::COUNT_W-1:0]       rsp_free_count
);
   import bpa_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // Sequencing and handshakes.
   bpa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_action (req_action),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // Bitmap, counts and response register.
   bpa_datapath #(
      .MAX_PAGES          (MAX_PAGES),
      .WORD_BITS          (WORD_BITS),
      .LOW_RESERVED_PAGES (LOW_RESERVED_PAGES)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .req_page_number    (req_page_number),
      .cmd                (cmd),
      .stat               (stat),
      .rsp_status         (rsp_status),
      .rsp_allocated_page (rsp_allocated_page),
      .rsp_used_count     (rsp_used_count),
      .rsp_free_count     (rsp_free_count)
   );

endmodule

>>> rtl/bpa_ctrl.sv
// ----------------------------------------------------------------------------
// Bitmap page allocator controller
// Sequences the reset clearing pass, initialize sweeps, allocation scans and
// frees, and owns the request and response handshakes.
// ----------------------------------------------------------------------------
module bpa_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [bpa_pkg::ACTION_W-1:0] req_action,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  bpa_pkg::dp_stat_type         stat,
   output bpa_pkg::dp_cmd_type          cmd
);
   import bpa_pkg::*;

   localparam logic [2:0] S_CLEAR    = 3'd0;
   localparam logic [2:0] S_IDLE     = 3'd1;
   localparam logic [2:0] S_FILL     = 3'd2;
   localparam logic [2:0] S_SCAN     = 3'd3;
   localparam logic [2:0] S_FREE_RD  = 3'd4;
   localparam logic [2:0] S_FREE_CHK = 3'd5;
   localparam logic [2:0] S_DONE     = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   // Next state and datapath commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.fill_run = 1'b1;
            if (stat.fill_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               unique case (req_action)
                  ACT_INIT: begin
                     cmd.fill_begin = 1'b1;
                     state_in       = S_FILL;
                  end
                  ACT_ALLOC: begin
                     cmd.scan_begin = 1'b1;
                     state_in       = S_SCAN;
                  end
                  ACT_FREE: begin
                     state_in = S_FREE_RD;
                  end
                  default: begin
                     cmd.nop_result = 1'b1;
                     state_in       = S_DONE;
                  end
               endcase
            end
         end
         S_FILL: begin
            cmd.fill_run = 1'b1;
            if (stat.fill_last) begin
               state_in = S_DONE;
            end
         end
         S_SCAN: begin
            if (stat.chk_valid && stat.found) begin
               cmd.alloc_commit = 1'b1;
               state_in         = S_DONE;
            end else if (stat.chk_valid && stat.last_word) begin
               cmd.alloc_fail = 1'b1;
               state_in       = S_DONE;
            end else begin
               cmd.scan_run = 1'b1;
            end
         end
         S_FREE_RD: begin
            if (stat.free_oor) begin
               cmd.free_oor = 1'b1;
               state_in     = S_DONE;
            end else begin
               cmd.free_read = 1'b1;
               state_in      = S_FREE_CHK;
            end
         end
         S_FREE_CHK: begin
            cmd.free_commit = 1'b1;
            state_in        = S_DONE;
         end
         S_DONE: begin
            // Wait for the output register to be free.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Response beat is held until taken.
   always_comb begin
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> rtl/bpa_datapath.sv
// ----------------------------------------------------------------------------
// Bitmap page allocator datapath
// Holds the used-page bitmap memory, the used count, the configuration
// registers, the sweep and scan pointers, and the response register.
// ----------------------------------------------------------------------------
module bpa_datapath #(
   parameter int MAX_PAGES          = 4096,
   parameter int WORD_BITS          = 32,
   parameter int LOW_RESERVED_PAGES = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_en,
   input  logic [bpa_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [bpa_pkg::CSR_DATA_W-1:0]    csr_write_data,
   input  logic [bpa_pkg::PAGE_W-1:0]        req_page_number,
   input  bpa_pkg::dp_cmd_type               cmd,
   output bpa_pkg::dp_stat_type              stat,
   output logic [bpa_pkg::STATUS_W-1:0]      rsp_status,
   output logic [bpa_pkg::PAGE_W-1:0]        rsp_allocated_page,
   output logic [bpa_pkg::COUNT_W-1:0]       rsp_used_count,
   output logic [bpa_pkg::COUNT_W-1:0]       rsp_free_count
);
   import bpa_pkg::*;

   localparam int MAP_WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
   localparam int WA        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int BW        = $clog2(WORD_BITS);
   localparam int CW        = $clog2(MAX_PAGES + 1);
   localparam int SPAN_W    = $clog2(MAP_WORDS * WORD_BITS + 1);
   localparam int XW        = (SPAN_W > CSR_DATA_W) ? SPAN_W : CSR_DATA_W;

   localparam logic [WA-1:0] LAST_WORD = WA'(MAP_WORDS - 1);
   localparam logic [XW-1:0] MAX_X     = XW'(MAX_PAGES);
   localparam logic [XW-1:0] LOW_RES_X = XW'(LOW_RESERVED_PAGES);
   localparam logic [XW-1:0] WORD_X    = XW'(WORD_BITS);

   // Bits of a word whose page number lies below a limit.
   function automatic logic [WORD_BITS-1:0] below_mask(input logic [XW-1:0] limit,
                                                       input logic [XW-1:0] base);
      logic [XW-1:0] span;
      begin
         span = limit - base;
         if (limit <= base) begin
            below_mask = '0;
         end else if (span >= WORD_X) begin
            below_mask = '1;
         end else begin
            below_mask = ~({WORD_BITS{1'b1}} << span[BW-1:0]);
         end
      end
   endfunction

   // Bitmap memory.
   logic [WORD_BITS-1:0] map_mem [MAP_WORDS];

   logic [CSR_DATA_W-1:0] cfg_pages_ff, cfg_reserved_ff;
   logic [CW-1:0]         used_ff, used_in;
   logic [WA-1:0]         fill_ptr_ff, fill_ptr_in;
   logic [XW-1:0]         fill_n_ff, fill_n_in;
   logic [WA-1:0]         scan_ptr_ff, scan_ptr_in;
   logic                  chk_vld_ff;
   logic [PAGE_W-1:0]     op_page_ff;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic [PAGE_W-1:0]     page_ff, page_in;
   logic [WORD_BITS-1:0]  rd_data_ff;
   logic [WA-1:0]         rd_idx_ff;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [PAGE_W-1:0]     rsp_page_ff;
   logic [COUNT_W-1:0]    rsp_used_ff, rsp_free_ff;

   logic [XW-1:0]         total_x, res_max_x, init_n_x, used_x, free_x;
   logic [XW-1:0]         op_page_x, op_word_x, chk_base_x, fill_base_x, found_page_x;
   logic [WORD_BITS-1:0]  range_mask, free_bits, fill_mask;
   logic [BW-1:0]         first_bit, op_bit;
   logic                  page_used;
   logic                  rd_en, wr_en;
   logic [WA-1:0]         rd_addr, wr_addr;
   logic [WORD_BITS-1:0]  wr_data;

   // Managed total and initialize reservation, both capped at capacity.
   assign total_x   = (XW'(cfg_pages_ff) < MAX_X) ? XW'(cfg_pages_ff) : MAX_X;
   assign res_max_x = (XW'(cfg_reserved_ff) > LOW_RES_X) ? XW'(cfg_reserved_ff) : LOW_RES_X;
   assign init_n_x  = (res_max_x < MAX_X) ? res_max_x : MAX_X;
   assign used_x    = XW'(used_ff);
   assign free_x    = (total_x > used_x) ? (total_x - used_x) : '0;

   // Page to free, split into word and bit.
   assign op_page_x = XW'(op_page_ff);
   assign op_word_x = op_page_x >> BW;
   assign op_bit    = op_page_ff[BW-1:0];

   // Scan check on the word just read.
   assign chk_base_x = XW'(rd_idx_ff) << BW;
   assign range_mask = below_mask(total_x, chk_base_x);
   assign free_bits  = ~rd_data_ff & range_mask;

   always_comb begin
      first_bit = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (free_bits[b]) begin
            first_bit = BW'(b);
         end
      end
   end

   assign found_page_x = chk_base_x + XW'(first_bit);
   assign page_used    = rd_data_ff[op_bit];

   // Sweep mask for the current fill word.
   assign fill_base_x = XW'(fill_ptr_ff) << BW;
   assign fill_mask   = below_mask(fill_n_ff, fill_base_x);

   assign stat.fill_last = (fill_ptr_ff == LAST_WORD);
   assign stat.chk_valid = chk_vld_ff;
   assign stat.found     = |free_bits;
   assign stat.last_word = (total_x <= chk_base_x + WORD_X);
   assign stat.free_oor  = (op_page_x >= total_x);

   // Memory port selection.
   always_comb begin
      rd_en   = cmd.scan_run || cmd.free_read;
      rd_addr = cmd.scan_run ? scan_ptr_ff : op_word_x[WA-1:0];
      wr_en   = 1'b0;
      wr_addr = rd_idx_ff;
      wr_data = rd_data_ff;
      if (cmd.fill_run) begin
         wr_en   = 1'b1;
         wr_addr = fill_ptr_ff;
         wr_data = fill_mask;
      end else if (cmd.alloc_commit) begin
         wr_en   = 1'b1;
         wr_data = rd_data_ff | (WORD_BITS'(1) << first_bit);
      end else if (cmd.free_commit && page_used) begin
         wr_en   = 1'b1;
         wr_data = rd_data_ff & ~(WORD_BITS'(1) << op_bit);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= map_mem[rd_addr];
         rd_idx_ff  <= rd_addr;
      end
   end

   // Pointers, count and step result.
   always_comb begin
      fill_ptr_in = fill_ptr_ff;
      fill_n_in   = fill_n_ff;
      scan_ptr_in = scan_ptr_ff;
      used_in     = used_ff;
      status_in   = status_ff;
      page_in     = page_ff;
      if (cmd.fill_begin) begin
         fill_ptr_in = '0;
         fill_n_in   = cmd.fill_zero ? '0 : init_n_x;
         used_in     = cmd.fill_zero ? '0 : init_n_x[CW-1:0];
         status_in   = STATUS_OK;
         page_in     = '0;
      end else if (cmd.fill_run && (fill_ptr_ff != LAST_WORD)) begin
         fill_ptr_in = fill_ptr_ff + 1'b1;
      end
      if (cmd.scan_begin) begin
         scan_ptr_in = '0;
      end else if (cmd.scan_run && (scan_ptr_ff != LAST_WORD)) begin
         scan_ptr_in = scan_ptr_ff + 1'b1;
      end
      if (cmd.alloc_commit) begin
         used_in   = used_ff + 1'b1;
         status_in = STATUS_OK;
         page_in   = found_page_x[PAGE_W-1:0];
      end
      if (cmd.alloc_fail) begin
         status_in = STATUS_NO_MEM;
         page_in   = '0;
      end
      if (cmd.free_oor) begin
         status_in = STATUS_RANGE;
         page_in   = '0;
      end
      if (cmd.free_commit) begin
         page_in = '0;
         if (page_used) begin
            status_in = STATUS_OK;
            if (used_ff != '0) begin
               used_in = used_ff - 1'b1;
            end
         end else begin
            status_in = STATUS_DOUBLE_FREE;
         end
      end
      if (cmd.nop_result) begin
         status_in = STATUS_OK;
         page_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_pages_ff    <= CSR_DATA_W'(4096);
         cfg_reserved_ff <= CSR_DATA_W'(256);
         used_ff         <= '0;
         fill_ptr_ff     <= '0;
         fill_n_ff       <= '0;
         scan_ptr_ff     <= '0;
         chk_vld_ff      <= 1'b0;
      end else begin
         if (csr_write_en && (csr_index == REG_PAGES)) begin
            cfg_pages_ff <= csr_write_data;
         end
         if (csr_write_en && (csr_index == REG_RESERVED)) begin
            cfg_reserved_ff <= csr_write_data;
         end
         used_ff     <= used_in;
         fill_ptr_ff <= fill_ptr_in;
         fill_n_ff   <= fill_n_in;
         scan_ptr_ff <= scan_ptr_in;
         chk_vld_ff  <= cmd.scan_run;
      end
   end

   // Request capture, step result and output register.
   always_ff @(posedge clock) begin
      status_ff <= status_in;
      page_ff   <= page_in;
      if (cmd.capture) begin
         op_page_ff <= req_page_number;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_page_ff   <= page_ff;
         rsp_used_ff   <= used_x[COUNT_W-1:0];
         rsp_free_ff   <= free_x[COUNT_W-1:0];
      end
   end

   assign rsp_status         = rsp_status_ff;
   assign rsp_allocated_page = rsp_page_ff;
   assign rsp_used_count     = rsp_used_ff;
   assign rsp_free_count     = rsp_free_ff;

endmodule

>>> bench/bitmap_page_allocator_core_tb.sv
// ----------------------------------------------------------------------------
// Bitmap page allocator core testbench
// Drives initialize, allocate and free beats into the allocator under random
// stalls on both channels and checks every response against a first-fit page
// map kept in the bench. A short directed table covers the corner cases, then
// random phases run under several page total and reservation settings.
// ----------------------------------------------------------------------------
module bitmap_page_allocator_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bpa_pkg::*;

   localparam int CLK_HALF      = 5;
   localparam int MAP_PAGES     = 4096;
   localparam int FLOOR_PAGES   = 256;
   localparam int PHASE_ITEMS   = 85;
   localparam int LONG_HOLD     = 300;
   localparam int SETTLE_CYCLES = 150;

   // The block leaves this action code undefined; it must change nothing.
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [PAGE_W-1:0]   page;
      logic [COUNT_W-1:0]  used;
      logic [COUNT_W-1:0]  free;
   } alloc_rsp_type;

   typedef struct {
      bit                     is_csr;
      logic [CSR_INDEX_W-1:0] reg_idx;
      logic [CSR_DATA_W-1:0]  reg_val;
      logic [ACTION_W-1:0]    act;
      logic [PAGE_W-1:0]      pg;
      bit                     fixed;
      alloc_rsp_type          rsp;
   } dir_row_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;
   logic                   req_valid;
   logic                   req_ready;
   logic [ACTION_W-1:0]    req_action;
   logic [PAGE_W-1:0]      req_page_number;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [STATUS_W-1:0]    rsp_status;
   logic [PAGE_W-1:0]      rsp_allocated_page;
   logic [COUNT_W-1:0]     rsp_used_count;
   logic [COUNT_W-1:0]     rsp_free_count;

   // Expectation travelling with the request beat for typed-in table rows.
   bit            drv_fixed;
   alloc_rsp_type drv_fixed_rsp;

   // Bench copy of the page map, the used count and the two registers.
   bit [MAP_PAGES-1:0] map_used;
   int                 model_used_cnt;
   int                 cfg_page_total;
   int                 cfg_reserved;
   int                 granted_q[$];
   int                 last_freed;

   alloc_rsp_type expected_rsp_q[$];
   dir_row_type   dir_rows[$];

   int errors;
   int items_sent;
   int rsp_checked;
   int csr_writes;
   int status_hits[4];
   bit quiet;
   bit hold_rsp;

   bitmap_page_allocator_core u_top (
      .clock              (clock),
      .reset              (reset),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_action         (req_action),
      .req_page_number    (req_page_number),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_allocated_page (rsp_allocated_page),
      .rsp_used_count     (rsp_used_count),
      .rsp_free_count     (rsp_free_count)
   );

   always #CLK_HALF clock = ~clock;

   // Pages actually managed: the page total register clipped to the map size.
   function automatic int managed_total();
      return (cfg_page_total < MAP_PAGES) ? cfg_page_total : MAP_PAGES;
   endfunction

   // First-fit allocator: applies one request beat to the bench map and
   // returns the response it must produce.
   task automatic page_alloc_predict(input logic [ACTION_W-1:0] act,
                                     input logic [PAGE_W-1:0] pg,
                                     output alloc_rsp_type r);
      int managed;
      int n;
      int i;
      bit hit;
      managed = managed_total();
      r       = '0;
      hit     = 1'b0;
      case (act)
         ACT_INIT: begin
            n = (cfg_reserved < FLOOR_PAGES) ? FLOOR_PAGES : cfg_reserved;
            if (n > MAP_PAGES)
               n = MAP_PAGES;
            map_used = '0;
            for (i = 0; i < n; i++)
               map_used[i] = 1'b1;
            model_used_cnt = n;
            granted_q.delete();
         end
         ACT_ALLOC: begin
            r.status = STATUS_NO_MEM;
            for (i = 0; i < managed && !hit; i++) begin
               if (!map_used[i]) begin
                  hit         = 1'b1;
                  map_used[i] = 1'b1;
                  model_used_cnt++;
                  r.page      = PAGE_W'(i);
                  r.status    = STATUS_OK;
                  granted_q.push_back(i);
               end
            end
         end
         ACT_FREE: begin
            if (pg >= managed) begin
               r.status = STATUS_RANGE;
            end else if (!map_used[pg]) begin
               r.status = STATUS_DOUBLE_FREE;
            end else begin
               map_used[pg] = 1'b0;
               if (model_used_cnt > 0)
                  model_used_cnt--;
               last_freed = pg;
            end
         end
         default: ;
      endcase
      r.used = COUNT_W'(model_used_cnt);
      r.free = (managed > model_used_cnt) ? COUNT_W'(managed - model_used_cnt) : '0;
   endtask

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         errors++;
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      end
   endfunction

   // Table rows: a typed-in expectation, a predicted one, or a register write.
   function automatic void row_check(logic [ACTION_W-1:0] act, logic [PAGE_W-1:0] pg,
                                     logic [STATUS_W-1:0] st, int page, int used,
                                     int free);
      dir_row_type r;
      r.is_csr     = 1'b0;
      r.reg_idx    = '0;
      r.reg_val    = '0;
      r.act        = act;
      r.pg         = pg;
      r.fixed      = 1'b1;
      r.rsp.status = st;
      r.rsp.page   = PAGE_W'(page);
      r.rsp.used   = COUNT_W'(used);
      r.rsp.free   = COUNT_W'(free);
      dir_rows.push_back(r);
   endfunction

   function automatic void row_pred(logic [ACTION_W-1:0] act, logic [PAGE_W-1:0] pg);
      dir_row_type r;
      r.is_csr  = 1'b0;
      r.reg_idx = '0;
      r.reg_val = '0;
      r.act     = act;
      r.pg      = pg;
      r.fixed   = 1'b0;
      r.rsp     = '0;
      dir_rows.push_back(r);
   endfunction

   function automatic void row_csr(logic [CSR_INDEX_W-1:0] idx, int val);
      dir_row_type r;
      r.is_csr  = 1'b1;
      r.reg_idx = idx;
      r.reg_val = CSR_DATA_W'(val);
      r.act     = ACT_INIT;
      r.pg      = '0;
      r.fixed   = 1'b0;
      r.rsp     = '0;
      dir_rows.push_back(r);
   endfunction

   // Offer one request beat, with an occasional random gap ahead of it, and return at
   // the falling edge after it was taken. Valid stays high for the next beat.
   task automatic send_item(input logic [ACTION_W-1:0] act, input logic [PAGE_W-1:0] pg,
                            input bit fixed, input alloc_rsp_type fixed_rsp);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_action      <= act;
      req_page_number <= pg;
      drv_fixed       <= fixed;
      drv_fixed_rsp   <= fixed_rsp;
      do @(posedge clock); while (!(req_valid && req_ready));
      @(negedge clock);
   endtask

   // Stop offering beats and wait for every outstanding response.
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_rsp_q.size() != 0) @(negedge clock);
   endtask

   // Register writes happen only with the block idle, so the bench copy is
   // updated right away.
   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx, input int val);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= CSR_DATA_W'(val);
      @(negedge clock);
      csr_write_en <= 1'b0;
      if (idx == REG_PAGES)
         cfg_page_total = val;
      else
         cfg_reserved = val;
      csr_writes++;
      @(negedge clock);
   endtask

   // Page to free: mostly a granted page, else a managed page, a repeat of
   // the last freed page, or anything the field can hold.
   function automatic logic [PAGE_W-1:0] pick_free_page();
      int r;
      int m;
      int k;
      int pg;
      m = managed_total();
      r = $urandom_range(0, 99);
      if (r < 55 && granted_q.size() > 0) begin
         k  = $urandom_range(0, granted_q.size() - 1);
         pg = granted_q[k];
         granted_q.delete(k);
      end else if (r < 75 && m > 0) begin
         pg = $urandom_range(0, m - 1);
      end else if (r < 85 && last_freed >= 0) begin
         pg = last_freed;
      end else begin
         pg = $urandom_range(0, MAP_PAGES - 1);
      end
      return PAGE_W'(pg);
   endfunction

   // One random phase under a fixed register setting.
   task automatic run_phase(input int pages, input int reserved, input bit do_init,
                            input bit long_hold);
      int                  done_items;
      int                  r;
      logic [ACTION_W-1:0] act;
      logic [PAGE_W-1:0]   pg;
      drain();
      csr_write(REG_PAGES, pages);
      csr_write(REG_RESERVED, reserved);
      if (long_hold)
         hold_rsp = 1'b1;
      if (do_init)
         send_item(ACT_INIT, PAGE_W'($urandom), 1'b0, '0);
      done_items = 0;
      while (done_items < PHASE_ITEMS) begin
         r = $urandom_range(0, 99);
         if (r < 47)
            act = ACT_ALLOC;
         else if (r < 90)
            act = ACT_FREE;
         else if (r < 94)
            act = ACT_INIT;
         else
            act = ACT_UNUSED;
         pg = (act == ACT_FREE) ? pick_free_page() : PAGE_W'($urandom);
         send_item(act, pg, 1'b0, '0);
         if (act != ACT_UNUSED)
            done_items++;
      end
   endtask

   // Request side: every accepted beat is run through the bench allocator.
   always @(posedge clock) begin : accept_mon
      alloc_rsp_type pred;
      if (!reset && req_valid && req_ready) begin
         page_alloc_predict(req_action, req_page_number, pred);
         expected_rsp_q.push_back(drv_fixed ? drv_fixed_rsp : pred);
         items_sent++;
      end
   end

   // Response side: compare each accepted beat with the oldest expectation.
   always @(posedge clock) begin : rsp_mon
      alloc_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp_q.size() == 0) begin
            errors++;
            $display({"%0t: unexpected response: expected none, ",
                      "actual status %0d page %0d used %0d free %0d"},
                     $time, rsp_status, rsp_allocated_page, rsp_used_count, rsp_free_count);
         end else begin
            want = expected_rsp_q.pop_front();
            check_field("status", want.status, rsp_status);
            check_field("allocated_page", want.page, rsp_allocated_page);
            check_field("used_count", want.used, rsp_used_count);
            check_field("free_count", want.free, rsp_free_count);
            rsp_checked++;
            status_hits[rsp_status]++;
         end
      end
   end

   // Receiver: random stall bursts, one long hold-off on request, none when quiet.
   initial begin
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            hold_rsp = 1'b0;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(negedge clock);
         end
      end
   end

   // Run limit, far beyond the slowest passing run.
   initial begin
      #10_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // Main sequence: reset, directed table, random phases, wind-down.
   initial begin
      reset           = 1'b1;
      csr_write_en    = 1'b0;
      csr_index       = '0;
      csr_write_data  = '0;
      req_valid       = 1'b0;
      req_action      = ACT_INIT;
      req_page_number = '0;
      drv_fixed       = 1'b0;
      drv_fixed_rsp   = '0;
      map_used        = '0;
      model_used_cnt  = 0;
      cfg_page_total  = MAP_PAGES;
      cfg_reserved    = FLOOR_PAGES;
      last_freed      = -1;
      errors          = 0;
      items_sent      = 0;
      rsp_checked     = 0;
      csr_writes      = 0;
      quiet           = 1'b0;
      hold_rsp        = 1'b0;
      foreach (status_hits[k])
         status_hits[k] = 0;

      // Map starts empty after the clearing pass, before any initialize.
      row_check(ACT_ALLOC, 12'hFFF, STATUS_OK, 0, 1, 4095);
      row_check(ACT_FREE, 12'h000, STATUS_OK, 0, 0, 4096);
      row_check(ACT_FREE, 12'h000, STATUS_DOUBLE_FREE, 0, 0, 4096);
      row_check(ACT_UNUSED, 12'hABC, STATUS_OK, 0, 0, 4096);
      row_check(ACT_INIT, 12'h000, STATUS_OK, 0, 256, 3840);
      row_check(ACT_ALLOC, 12'h000, STATUS_OK, 256, 257, 3839);
      row_check(ACT_FREE, 12'hFFF, STATUS_DOUBLE_FREE, 0, 257, 3839);
      row_check(ACT_FREE, 12'h100, STATUS_OK, 0, 256, 3840);
      row_check(ACT_FREE, 12'h000, STATUS_OK, 0, 255, 3841);
      row_pred(ACT_ALLOC, 12'h555);
      // Page total below the reservation: free count saturates at zero.
      row_csr(REG_PAGES, 100);
      row_check(ACT_FREE, 12'd100, STATUS_RANGE, 0, 256, 0);
      row_check(ACT_ALLOC, 12'h000, STATUS_NO_MEM, 0, 256, 0);
      row_pred(ACT_FREE, 12'd99);
      row_csr(REG_PAGES, 0);
      row_check(ACT_FREE, 12'h000, STATUS_RANGE, 0, 255, 0);
      row_check(ACT_ALLOC, 12'h000, STATUS_NO_MEM, 0, 255, 0);
      // Both registers above capacity: everything reserved.
      row_csr(REG_PAGES, 8191);
      row_csr(REG_RESERVED, 8191);
      row_check(ACT_INIT, 12'hFFF, STATUS_OK, 0, 4096, 0);
      row_check(ACT_ALLOC, 12'h000, STATUS_NO_MEM, 0, 4096, 0);
      row_check(ACT_FREE, 12'hFFF, STATUS_OK, 0, 4095, 1);
      row_check(ACT_ALLOC, 12'h000, STATUS_OK, 4095, 4096, 0);
      // Reservation below the low reserved floor.
      row_csr(REG_RESERVED, 0);
      row_check(ACT_INIT, 12'h000, STATUS_OK, 0, 256, 3840);
      row_csr(REG_PAGES, 300);
      row_csr(REG_RESERVED, 290);
      row_pred(ACT_INIT, 12'h3C3);
      row_pred(ACT_ALLOC, 12'h000);
      row_pred(ACT_FREE, 12'hFFF);

      repeat (12) @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[k]) begin
         if (dir_rows[k].is_csr) begin
            drain();
            csr_write(dir_rows[k].reg_idx, dir_rows[k].reg_val);
         end else begin
            send_item(dir_rows[k].act, dir_rows[k].pg, dir_rows[k].fixed, dir_rows[k].rsp);
         end
      end

      run_phase(4096, 256, 1'b1, 1'b1);
      run_phase(270, 256, 1'b1, 1'b0);
      run_phase($urandom_range(0, 8191), $urandom_range(0, 8191), 1'b0, 1'b0);
      run_phase(8191, 4000, 1'b1, 1'b0);
      run_phase(4096, 0, 1'b1, 1'b0);
      run_phase($urandom_range(256, 400), $urandom_range(0, 300), 1'b1, 1'b0);
      run_phase($urandom_range(0, 8191), $urandom_range(0, 4096), 1'b1, 1'b0);
      run_phase(300, 8191, 1'b1, 1'b0);
      quiet = 1'b1;
      run_phase(4096, 256, 1'b1, 1'b0);

      drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (expected_rsp_q.size() != 0) begin
         errors++;
         $display("%0t: %0d responses never arrived", $time, expected_rsp_q.size());
      end

      $display("Sent %0d request beats and checked %0d responses across %0d register writes.",
               items_sent, rsp_checked, csr_writes);
      $display("Responses seen: %0d ok, %0d out of memory, %0d double free, %0d out of range.",
               status_hits[STATUS_OK], status_hits[STATUS_NO_MEM],
               status_hits[STATUS_DOUBLE_FREE], status_hits[STATUS_RANGE]);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/bpa_pkg.sv
rtl/bpa_ctrl.sv
rtl/bpa_datapath.sv
rtl/bitmap_page_allocator_core.sv
bench/bitmap_page_allocator_core_tb.sv
